// File: rtl/tspc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and the command type of the tile sprite compositor.
// No dependencies; used by every module of the block except tspc_ram.
`default_nettype none

package tspc_pkg;

  localparam int MAP_SIDE_DEF      = 128;
  localparam int MAX_SPRITE_DEF    = 8;
  localparam int TILE_COUNT_DEF    = 2048;
  localparam int PRIORITY_BITS_DEF = 8;

  // Command fields are sized for the widest legal parameter values.
  localparam int COORD_W_MAX = 8;
  localparam int TILE_W_MAX  = 16;
  localparam int PRI_W_MAX   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] KIND_DRAW    = 3'd0;
  localparam logic [2:0] KIND_ERASE   = 3'd1;
  localparam logic [2:0] KIND_WR_VIEW = 3'd2;
  localparam logic [2:0] KIND_WR_BG   = 3'd3;
  localparam logic [2:0] KIND_WR_PRI  = 3'd4;
  localparam logic [2:0] KIND_RD_VIEW = 3'd5;

  typedef struct packed {
    logic [2:0]             kind;
    logic [COORD_W_MAX-1:0] col;   // already reduced modulo the map side
    logic [COORD_W_MAX-1:0] row;
    logic [TILE_W_MAX-1:0]  tile;  // base tile, cell tile or priority index
    logic [3:0]             size;  // clamped edge length
    logic [PRI_W_MAX-1:0]   pri;   // priority value for priority writes
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/tspc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/tspc_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front and the back of the compositor.
// Depends on tspc_pkg for the command type and depth.
`default_nettype none

module tspc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tspc_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output tspc_pkg::cmd_t     head_cmd,
  output logic               empty
);

  localparam int PW = $clog2(tspc_pkg::QUEUE_DEPTH);

  tspc_pkg::cmd_t entry_r [tspc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    count_r;

  assign full     = (count_r == (PW+1)'(tspc_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(tspc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(tspc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tspc_front.sv
`timescale 1ns / 1ps
// Front end: accepts an item, computes the base tile of a draw and reduces coordinates
// and tile numbers into range, then pushes a command. Depends on tspc_pkg.
`default_nettype none

module tspc_front #(
  parameter int MAP_SIDE      = tspc_pkg::MAP_SIDE_DEF,
  parameter int MAX_SPRITE    = tspc_pkg::MAX_SPRITE_DEF,
  parameter int TILE_COUNT    = tspc_pkg::TILE_COUNT_DEF,
  parameter int PRIORITY_BITS = tspc_pkg::PRIORITY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [6:0]  in_col,
  input  wire logic [6:0]  in_row,
  input  wire logic [10:0] in_first_tile,
  input  wire logic [3:0]  in_obj_size,
  input  wire logic [2:0]  in_direction,
  input  wire logic [2:0]  in_dir_mask,
  input  wire logic [3:0]  in_stage_count,
  input  wire logic [3:0]  in_stage,
  input  wire logic [10:0] in_data,
  output logic             push,
  output tspc_pkg::cmd_t   push_cmd,
  input  wire logic        full
);

  localparam int RW = 9;   // holds any input coordinate and MAP_SIDE itself
  localparam int TRW = 17; // holds any base-tile sum and TILE_COUNT itself

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_RED, F_PUSH} fstate_t;

  fstate_t                  state_r;
  logic [2:0]               kind_r;
  logic [RW-1:0]            col_r;
  logic [RW-1:0]            row_r;
  logic [TRW-1:0]           tile_r;
  logic [3:0]               size_r;
  logic [PRIORITY_BITS-1:0] pri_r;
  logic [10:0]              first_r;
  logic [6:0]               sq_r;
  logic [6:0]               idx_r;
  logic                     col_big;
  logic                     row_big;
  logic                     tile_big;
  logic [3:0]               size_clamped;

  assign in_ready     = (state_r == F_IDLE);
  assign col_big      = (col_r >= RW'(MAP_SIDE));
  assign row_big      = (row_r >= RW'(MAP_SIDE));
  assign tile_big     = (tile_r >= TRW'(TILE_COUNT));
  assign size_clamped = (in_obj_size > 4'(MAX_SPRITE)) ? 4'(MAX_SPRITE) : in_obj_size;
  assign push         = (state_r == F_PUSH) && !full;

  always_comb begin
    push_cmd      = '0;
    push_cmd.kind = kind_r;
    push_cmd.col  = tspc_pkg::COORD_W_MAX'(col_r);
    push_cmd.row  = tspc_pkg::COORD_W_MAX'(row_r);
    push_cmd.tile = tspc_pkg::TILE_W_MAX'(tile_r);
    push_cmd.size = size_r;
    push_cmd.pri  = tspc_pkg::PRI_W_MAX'(pri_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_kind;
            col_r   <= RW'(in_col);
            row_r   <= RW'(in_row);
            size_r  <= size_clamped;
            first_r <= in_first_tile;
            pri_r   <= PRIORITY_BITS'(in_data);
            sq_r    <= 7'(size_clamped) * 7'(size_clamped);
            idx_r   <= 7'(in_direction & in_dir_mask) * 7'(in_stage_count) + 7'(in_stage);
            tile_r  <= (in_kind == tspc_pkg::KIND_WR_PRI) ? TRW'(in_first_tile)
                                                          : TRW'(in_data);
            state_r <= (in_kind == tspc_pkg::KIND_DRAW) ? F_MUL : F_RED;
          end
        end
        F_MUL: begin
          tile_r  <= TRW'(first_r) + TRW'(sq_r) * TRW'(idx_r);
          state_r <= F_RED;
        end
        F_RED: begin
          // one subtract per cycle on each value still out of range
          if (col_big) begin
            col_r <= col_r - RW'(MAP_SIDE);
          end
          if (row_big) begin
            row_r <= row_r - RW'(MAP_SIDE);
          end
          if (tile_big) begin
            tile_r <= tile_r - TRW'(TILE_COUNT);
          end
          if (!col_big && !row_big && !tile_big) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/tspc_back.sv
`timescale 1ns / 1ps
// Back end: owns the view, background and priority stores, clears them after
// reset and executes queued commands. Depends on tspc_pkg and tspc_ram.
`default_nettype none

module tspc_back #(
  parameter int MAP_SIDE      = tspc_pkg::MAP_SIDE_DEF,
  parameter int TILE_COUNT    = tspc_pkg::TILE_COUNT_DEF,
  parameter int PRIORITY_BITS = tspc_pkg::PRIORITY_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire tspc_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [10:0]         out_read_tile,
  output logic [6:0]          out_cells_changed
);

  localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
  localparam int CW        = $clog2(MAP_SIDE);
  localparam int AW        = $clog2(MAP_CELLS);
  localparam int TW        = $clog2(TILE_COUNT);
  localparam int PB        = PRIORITY_BITS;
  localparam int CLR_N     = (MAP_CELLS > TILE_COUNT) ? MAP_CELLS : TILE_COUNT;
  localparam int CLW       = $clog2(CLR_N) + 1;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_PRIW, B_RUN, B_RDW} bstate_t;

  bstate_t        state_r;
  logic [CLW-1:0] clr_r;
  logic           out_valid_r;
  logic [10:0]    out_tile_r;
  logic [6:0]     out_cells_r;
  logic [TW-1:0]  last_tile_r;
  logic [CW-1:0]  last_col_r;
  logic [CW-1:0]  last_row_r;
  logic           is_draw_r;
  logic [3:0]     size_r;
  logic [3:0]     x_r;
  logic [3:0]     y_r;
  logic [CW-1:0]  c0_r;
  logic [CW-1:0]  c_r;
  logic [CW-1:0]  r_r;
  logic [TW-1:0]  t_r;
  logic [PB-1:0]  spri_r;
  logic           issuing_r;
  logic [6:0]     cnt_r;
  logic           p1_v_r;
  logic [AW-1:0]  p1_addr_r;
  logic [TW-1:0]  p1_tile_r;
  logic           p2_v_r;
  logic [AW-1:0]  p2_addr_r;
  logic [TW-1:0]  p2_tile_r;
  logic [TW-1:0]  p2_view_r;
  logic [TW-1:0]  p2_bg_r;

  logic           vw_we, bg_we, pr_we, vw_re, bg_re, pr_re;
  logic [AW-1:0]  vw_waddr, bg_waddr, vw_raddr;
  logic [TW-1:0]  vw_wdata, bg_wdata, pr_waddr, pr_raddr;
  logic [PB-1:0]  pr_wdata;
  logic [TW-1:0]  vw_rdata, bg_rdata;
  logic [PB-1:0]  pr_rdata;

  logic [AW-1:0]  a_cur;
  logic [AW-1:0]  a_cmd;
  logic           hit;
  logic           take;
  logic           run_done;
  logic [CW-1:0]  c_inc, r_inc;
  logic [TW-1:0]  t_inc;

  assign out_valid         = out_valid_r;
  assign out_read_tile     = out_tile_r;
  assign out_cells_changed = out_cells_r;

  assign a_cur = AW'(r_r) * AW'(MAP_SIDE) + AW'(c_r);
  assign a_cmd = AW'(q_cmd.row[CW-1:0]) * AW'(MAP_SIDE) + AW'(q_cmd.col[CW-1:0]);
  assign c_inc = (c_r == CW'(MAP_SIDE - 1)) ? '0 : c_r + 1'b1;
  assign r_inc = (r_r == CW'(MAP_SIDE - 1)) ? '0 : r_r + 1'b1;
  assign t_inc = (t_r == TW'(TILE_COUNT - 1)) ? '0 : t_r + 1'b1;

  assign take     = (state_r == B_IDLE) && !q_empty && !out_valid_r;
  assign q_pop    = take;
  assign hit      = p2_v_r && (is_draw_r ? (pr_rdata <= spri_r) : (p2_view_r == p2_tile_r));
  assign run_done = (state_r == B_RUN) && !issuing_r && !p1_v_r && !p2_v_r;

  // Store port selection.
  always_comb begin
    vw_we    = 1'b0;
    bg_we    = 1'b0;
    pr_we    = 1'b0;
    vw_waddr = a_cmd;
    bg_waddr = a_cmd;
    pr_waddr = q_cmd.tile[TW-1:0];
    vw_wdata = q_cmd.tile[TW-1:0];
    bg_wdata = q_cmd.tile[TW-1:0];
    pr_wdata = q_cmd.pri[PB-1:0];
    vw_re    = 1'b0;
    bg_re    = 1'b0;
    vw_raddr = a_cur;
    pr_re    = p1_v_r;
    pr_raddr = vw_rdata;
    priority case (1'b1)
      state_r == B_CLEAR: begin
        vw_we    = ({1'b0, clr_r} < (CLW+1)'(MAP_CELLS));
        bg_we    = vw_we;
        pr_we    = ({1'b0, clr_r} < (CLW+1)'(TILE_COUNT));
        vw_waddr = clr_r[AW-1:0];
        bg_waddr = clr_r[AW-1:0];
        pr_waddr = clr_r[TW-1:0];
        vw_wdata = '0;
        bg_wdata = '0;
        pr_wdata = '0;
      end
      take: begin
        vw_we    = (q_cmd.kind == tspc_pkg::KIND_WR_VIEW);
        bg_we    = (q_cmd.kind == tspc_pkg::KIND_WR_BG);
        pr_we    = (q_cmd.kind == tspc_pkg::KIND_WR_PRI);
        vw_re    = (q_cmd.kind == tspc_pkg::KIND_RD_VIEW);
        vw_raddr = a_cmd;
        pr_re    = (q_cmd.kind == tspc_pkg::KIND_DRAW);
        pr_raddr = q_cmd.tile[TW-1:0];
      end
      state_r == B_RUN: begin
        vw_re    = issuing_r;
        bg_re    = issuing_r;
        vw_we    = hit;
        vw_waddr = p2_addr_r;
        vw_wdata = is_draw_r ? p2_tile_r : p2_bg_r;
      end
      default: ;
    endcase
  end

  tspc_ram #(.WIDTH(TW), .DEPTH(MAP_CELLS)) u_view (
    .clk(clk), .wr_en(vw_we), .wr_addr(vw_waddr), .wr_data(vw_wdata),
    .rd_en(vw_re), .rd_addr(vw_raddr), .rd_data(vw_rdata)
  );

  tspc_ram #(.WIDTH(TW), .DEPTH(MAP_CELLS)) u_background (
    .clk(clk), .wr_en(bg_we), .wr_addr(bg_waddr), .wr_data(bg_wdata),
    .rd_en(bg_re), .rd_addr(a_cur), .rd_data(bg_rdata)
  );

  tspc_ram #(.WIDTH(PB), .DEPTH(TILE_COUNT)) u_priority (
    .clk(clk), .wr_en(pr_we), .wr_addr(pr_waddr), .wr_data(pr_wdata),
    .rd_en(pr_re), .rd_addr(pr_raddr), .rd_data(pr_rdata)
  );

  // Cell pipeline payload: read view/background, then priority, then write.
  always_ff @(posedge clk) begin
    p1_addr_r <= a_cur;
    p1_tile_r <= t_r;
    p2_addr_r <= p1_addr_r;
    p2_tile_r <= p1_tile_r;
    p2_view_r <= vw_rdata;
    p2_bg_r   <= bg_rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      last_tile_r <= '0;
      last_col_r  <= '0;
      last_row_r  <= '0;
      issuing_r   <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      p1_v_r <= (state_r == B_RUN) && issuing_r;
      p2_v_r <= p1_v_r;
      if (hit) begin
        cnt_r <= cnt_r + 1'b1;
      end
      unique case (state_r)
        B_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLW'(CLR_N - 1)) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (take) begin
            is_draw_r <= (q_cmd.kind == tspc_pkg::KIND_DRAW);
            size_r    <= q_cmd.size;
            x_r       <= '0;
            y_r       <= '0;
            cnt_r     <= '0;
            issuing_r <= (q_cmd.size != '0);
            unique case (q_cmd.kind)
              tspc_pkg::KIND_DRAW: begin
                last_tile_r <= q_cmd.tile[TW-1:0];
                last_col_r  <= q_cmd.col[CW-1:0];
                last_row_r  <= q_cmd.row[CW-1:0];
                c0_r        <= q_cmd.col[CW-1:0];
                c_r         <= q_cmd.col[CW-1:0];
                r_r         <= q_cmd.row[CW-1:0];
                t_r         <= q_cmd.tile[TW-1:0];
                state_r     <= B_PRIW;
              end
              tspc_pkg::KIND_ERASE: begin
                c0_r    <= last_col_r;
                c_r     <= last_col_r;
                r_r     <= last_row_r;
                t_r     <= last_tile_r;
                state_r <= B_RUN;
              end
              tspc_pkg::KIND_RD_VIEW: begin
                state_r <= B_RDW;
              end
              default: begin
                out_valid_r <= 1'b1;
                out_tile_r  <= '0;
                out_cells_r <= '0;
              end
            endcase
          end
        end
        B_PRIW: begin
          spri_r  <= pr_rdata;
          state_r <= B_RUN;
        end
        B_RUN: begin
          if (issuing_r) begin
            t_r <= t_inc;
            if (x_r == size_r - 1'b1) begin
              x_r <= '0;
              c_r <= c0_r;
              r_r <= r_inc;
              y_r <= y_r + 1'b1;
              if (y_r == size_r - 1'b1) begin
                issuing_r <= 1'b0;
              end
            end else begin
              x_r <= x_r + 1'b1;
              c_r <= c_inc;
            end
          end
          if (run_done) begin
            out_valid_r <= 1'b1;
            out_tile_r  <= '0;
            out_cells_r <= cnt_r;
            state_r     <= B_IDLE;
          end
        end
        B_RDW: begin
          out_valid_r <= 1'b1;
          out_tile_r  <= 11'(vw_rdata);
          out_cells_r <= '0;
          state_r     <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/tile_sprite_priority_compositor.sv
`timescale 1ns / 1ps
// Top level of the tile sprite compositor: front end, command queue, back end.
// Depends on tspc_pkg, tspc_front, tspc_queue and tspc_back.
//
//   channel   handshake              payload
//   in_       in_valid / in_ready    kind col row first_tile obj_size direction
//                                    dir_mask stage_count stage data
//   out_      out_valid / out_ready  read_tile cells_changed
//
// Front end: captures the item, computes the base tile for a draw, reduces
// coordinates and tile numbers by repeated subtraction, then pushes. Back end:
// the cell pipeline is view read, priority read, view write. After reset the
// stores are swept to zero over max(MAP_SIDE*MAP_SIDE, TILE_COUNT) addresses
// (16384 at defaults) before the first command runs. A stalled output holds
// the back end; the two-entry queue lets the front keep accepting meanwhile.
`default_nettype none

module tile_sprite_priority_compositor #(
  parameter int MAP_SIDE      = tspc_pkg::MAP_SIDE_DEF,
  parameter int MAX_SPRITE    = tspc_pkg::MAX_SPRITE_DEF,
  parameter int TILE_COUNT    = tspc_pkg::TILE_COUNT_DEF,
  parameter int PRIORITY_BITS = tspc_pkg::PRIORITY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [6:0]  in_col,
  input  wire logic [6:0]  in_row,
  input  wire logic [10:0] in_first_tile,
  input  wire logic [3:0]  in_obj_size,
  input  wire logic [2:0]  in_direction,
  input  wire logic [2:0]  in_dir_mask,
  input  wire logic [3:0]  in_stage_count,
  input  wire logic [3:0]  in_stage,
  input  wire logic [10:0] in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      out_read_tile,
  output logic [6:0]       out_cells_changed
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  tspc_pkg::cmd_t push_cmd;
  tspc_pkg::cmd_t head_cmd;

  tspc_front #(
    .MAP_SIDE(MAP_SIDE), .MAX_SPRITE(MAX_SPRITE),
    .TILE_COUNT(TILE_COUNT), .PRIORITY_BITS(PRIORITY_BITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_col(in_col), .in_row(in_row),
    .in_first_tile(in_first_tile), .in_obj_size(in_obj_size),
    .in_direction(in_direction), .in_dir_mask(in_dir_mask),
    .in_stage_count(in_stage_count), .in_stage(in_stage), .in_data(in_data),
    .push(push), .push_cmd(push_cmd), .full(full)
  );

  tspc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_cmd(push_cmd), .full(full),
    .pop(pop), .head_cmd(head_cmd), .empty(empty)
  );

  tspc_back #(
    .MAP_SIDE(MAP_SIDE), .TILE_COUNT(TILE_COUNT), .PRIORITY_BITS(PRIORITY_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(empty), .q_cmd(head_cmd), .q_pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_tile(out_read_tile), .out_cells_changed(out_cells_changed)
  );

endmodule

`default_nettype wire
